>>> src/jsv_pkg.sv
package jsv_pkg;

    // default sizes of the nesting stack and of the number length counter
    localparam int JSV_MAX_LEVEL     = 32;
    localparam int JSV_NUMBER_BUFFER = 64;

    // register indexes of the configuration port
    localparam logic REG_LEVEL_LIMIT  = 1'b0;
    localparam logic REG_NUMBER_LIMIT = 1'b1;

    // register reset values
    localparam logic [5:0] LEVEL_LIMIT_RESET  = 6'd32;
    localparam logic [5:0] NUMBER_LIMIT_RESET = 6'd63;

    // result status codes
    localparam logic [1:0] ST_FINE      = 2'd0;
    localparam logic [1:0] ST_ERROR     = 2'd1;
    localparam logic [1:0] ST_END_VALID = 2'd2;
    localparam logic [1:0] ST_END_BAD   = 2'd3;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_L   = 8'h6C;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_S   = 8'h73;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // literal kinds
    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    // number of hex digits after a unicode escape
    localparam logic [2:0] HEX_DIGITS = 3'd4;

    // parser phase
    typedef enum logic [4:0] {
        PH_VALUE     = 5'd0,
        PH_ARR_FIRST = 5'd1,
        PH_OBJ_FIRST = 5'd2,
        PH_KEY       = 5'd3,
        PH_COLON     = 5'd4,
        PH_AFTER     = 5'd5,
        PH_DONE      = 5'd6,
        PH_STR       = 5'd7,
        PH_STR_ESC   = 5'd8,
        PH_STR_HEX   = 5'd9,
        PH_KSTR      = 5'd10,
        PH_KSTR_ESC  = 5'd11,
        PH_KSTR_HEX  = 5'd12,
        PH_LIT       = 5'd13,
        PH_NSIGN     = 5'd14,
        PH_NZERO     = 5'd15,
        PH_NINT      = 5'd16,
        PH_NDOT      = 5'd17,
        PH_NFRAC     = 5'd18,
        PH_NEXP      = 5'd19,
        PH_NEXPS     = 5'd20,
        PH_NEXPD     = 5'd21
    } phase_t;

    // stack control from the parser
    typedef struct packed {
        logic push;
        logic pop;
        logic push_obj;
    } stack_ctrl_t;

    // one result
    typedef struct packed {
        logic [1:0] status;
        logic [5:0] open_containers;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F);
    endfunction

    function automatic logic is_exp(input logic [7:0] c);
        return c == CH_LO_E || c == CH_UP_E;
    endfunction

    // number phases where the text may legally stop
    function automatic logic num_can_end(input phase_t ph);
        return ph == PH_NZERO || ph == PH_NINT || ph == PH_NFRAC || ph == PH_NEXPD;
    endfunction

    function automatic logic is_num_phase(input phase_t ph);
        return ph >= PH_NSIGN && ph <= PH_NEXPD;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        logic [2:0] len;
        case (kind)
            LIT_FALSE: len = 3'd5;
            default:   len = 3'd4;
        endcase
        return len;
    endfunction

    // letters of true, false and null
    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
        logic [7:0] ch;
        ch = CH_NUL;
        case (kind)
            LIT_TRUE: begin
                case (idx)
                    3'd0:    ch = CH_LO_T;
                    3'd1:    ch = CH_LO_R;
                    3'd2:    ch = CH_LO_U;
                    3'd3:    ch = CH_LO_E;
                    default: ch = CH_NUL;
                endcase
            end
            LIT_FALSE: begin
                case (idx)
                    3'd0:    ch = CH_LO_F;
                    3'd1:    ch = CH_LO_A;
                    3'd2:    ch = CH_LO_L;
                    3'd3:    ch = CH_LO_S;
                    3'd4:    ch = CH_LO_E;
                    default: ch = CH_NUL;
                endcase
            end
            LIT_NULL: begin
                case (idx)
                    3'd0:    ch = CH_LO_N;
                    3'd1:    ch = CH_LO_U;
                    3'd2:    ch = CH_LO_L;
                    3'd3:    ch = CH_LO_L;
                    default: ch = CH_NUL;
                endcase
            end
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

>>> src/jsv_stack.sv
module jsv_stack import jsv_pkg::*; #(
    parameter int MAX_LEVEL = JSV_MAX_LEVEL,
    parameter int LVL_W     = $clog2(MAX_LEVEL + 2)
) (
    input  logic             aclk,
    input  stack_ctrl_t      ctrl,
    input  logic [LVL_W-1:0] level,
    input  logic [LVL_W-1:0] level_next,
    output logic             top_obj
);

    localparam int IDX_W = $clog2(MAX_LEVEL + 1);

    // one bit per open container, 1 for object
    logic             mem [MAX_LEVEL + 1];
    logic             top_reg;
    logic             below_reg;
    logic [LVL_W-1:0] below_lvl;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;

    assign wr_idx    = level[IDX_W-1:0];
    assign below_lvl = level_next - LVL_W'(2);
    assign rd_idx    = (level_next >= LVL_W'(2)) ? below_lvl[IDX_W-1:0] : '0;

    // push writes the new top, the entry under the next top is prefetched
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[wr_idx] <= ctrl.push_obj;
        end
        below_reg <= mem[rd_idx];
    end

    // top of stack kept in a flop
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            top_reg <= ctrl.push_obj;
        end else if (ctrl.pop) begin
            top_reg <= below_reg;
        end
    end

    assign top_obj = top_reg;

endmodule

>>> src/jsv_core.sv
module jsv_core import jsv_pkg::*; #(
    parameter int MAX_LEVEL     = JSV_MAX_LEVEL,
    parameter int NUMBER_BUFFER = JSV_NUMBER_BUFFER,
    parameter int LVL_W         = $clog2(MAX_LEVEL + 2)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       text_byte,
    input  logic             final_byte,
    input  logic [5:0]       level_limit,
    input  logic [5:0]       number_limit,
    input  logic             top_obj,
    output stack_ctrl_t      stk_ctrl,
    output logic [LVL_W-1:0] level,
    output logic [LVL_W-1:0] level_next,
    output result_t          result
);

    localparam int CMP_W   = (LVL_W > 6) ? LVL_W : 6;
    localparam int NUM_CAP = (NUMBER_BUFFER - 1 < 63) ? NUMBER_BUFFER - 1 : 63;

    phase_t           ph_reg, ph_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [2:0]       sub_reg, sub_next;
    logic [1:0]       kind_reg, kind_next;
    logic [5:0]       nlen_reg, nlen_next;
    logic             err_reg, err_next;
    logic             ended_reg, ended_next;

    logic [CMP_W-1:0] eff_lvl;
    logic [5:0]       eff_num;
    logic             too_deep;
    logic             stack_full;
    logic             num_over;
    logic             top_is_obj;

    // effective limits, clamped to what the storage holds
    always_comb begin
        if (CMP_W'(level_limit) > CMP_W'(MAX_LEVEL)) begin
            eff_lvl = CMP_W'(MAX_LEVEL);
        end else begin
            eff_lvl = CMP_W'(level_limit);
        end
        if (number_limit > 6'(NUM_CAP)) begin
            eff_num = 6'(NUM_CAP);
        end else begin
            eff_num = number_limit;
        end
    end

    assign too_deep   = CMP_W'(lvl_reg) > eff_lvl;
    assign stack_full = lvl_reg > LVL_W'(MAX_LEVEL);
    assign num_over   = ({1'b0, nlen_reg} + 7'd1) > {1'b0, eff_num};
    assign top_is_obj = (lvl_reg != '0) && top_obj;

    // byte parser
    always_comb begin
        logic   active;
        logic   fail;
        logic   run_sw;
        logic   do_start;
        logic   do_close;
        logic   key;
        logic   num_ok;
        logic   end_now;
        logic   err_mid;
        phase_t num_ph;
        phase_t ph_sw;
        logic [2:0] sub_inc;

        ph_next    = ph_reg;
        lvl_next   = lvl_reg;
        sub_next   = sub_reg;
        kind_next  = kind_reg;
        nlen_next  = nlen_reg;
        ended_next = ended_reg;
        stk_ctrl   = '0;
        fail       = 1'b0;
        run_sw     = 1'b0;
        do_start   = 1'b0;
        do_close   = 1'b0;
        num_ok     = 1'b0;
        num_ph     = ph_reg;
        ph_sw      = ph_reg;
        end_now    = 1'b0;
        key        = (ph_reg == PH_KSTR) || (ph_reg == PH_KSTR_ESC) || (ph_reg == PH_KSTR_HEX);
        sub_inc    = sub_reg + 3'd1;
        active     = step && !err_reg && !ended_reg;

        // number grammar step
        case (ph_reg)
            PH_NSIGN: begin
                if (text_byte == CH_ZERO) begin
                    num_ok = 1'b1; num_ph = PH_NZERO;
                end else if (is_digit(text_byte)) begin
                    num_ok = 1'b1; num_ph = PH_NINT;
                end
            end
            PH_NZERO: begin
                if (text_byte == CH_DOT) begin
                    num_ok = 1'b1; num_ph = PH_NDOT;
                end else if (is_exp(text_byte)) begin
                    num_ok = 1'b1; num_ph = PH_NEXP;
                end
            end
            PH_NINT: begin
                if (is_digit(text_byte)) begin
                    num_ok = 1'b1; num_ph = PH_NINT;
                end else if (text_byte == CH_DOT) begin
                    num_ok = 1'b1; num_ph = PH_NDOT;
                end else if (is_exp(text_byte)) begin
                    num_ok = 1'b1; num_ph = PH_NEXP;
                end
            end
            PH_NDOT: begin
                if (is_digit(text_byte)) begin
                    num_ok = 1'b1; num_ph = PH_NFRAC;
                end
            end
            PH_NFRAC: begin
                if (is_digit(text_byte)) begin
                    num_ok = 1'b1; num_ph = PH_NFRAC;
                end else if (is_exp(text_byte)) begin
                    num_ok = 1'b1; num_ph = PH_NEXP;
                end
            end
            PH_NEXP: begin
                if (text_byte == CH_PLUS || text_byte == CH_MINUS) begin
                    num_ok = 1'b1; num_ph = PH_NEXPS;
                end else if (is_digit(text_byte)) begin
                    num_ok = 1'b1; num_ph = PH_NEXPD;
                end
            end
            default: begin
                if (is_digit(text_byte)) begin
                    num_ok = 1'b1; num_ph = PH_NEXPD;
                end
            end
        endcase

        if (active) begin
            if (text_byte == CH_NUL) begin
                end_now = 1'b1;
            end else if (is_num_phase(ph_reg)) begin
                if (num_ok) begin
                    ph_next = num_ph;
                    if (num_over) begin
                        fail = 1'b1;
                    end else begin
                        nlen_next = nlen_reg + 6'd1;
                    end
                end else if (num_can_end(ph_reg)) begin
                    // number ends here, the byte is parsed again after it
                    ph_sw  = (lvl_reg == '0) ? PH_DONE : PH_AFTER;
                    run_sw = 1'b1;
                end else begin
                    fail = 1'b1;
                end
            end else begin
                run_sw = 1'b1;
            end
        end

        // structural phases
        if (run_sw) begin
            ph_next = ph_sw;
            case (ph_sw)
                PH_VALUE: begin
                    if (!is_space(text_byte)) begin
                        do_start = 1'b1;
                    end
                end
                PH_ARR_FIRST: begin
                    if (text_byte == CH_RBRACK) begin
                        do_close = 1'b1;
                    end else if (!is_space(text_byte)) begin
                        do_start = 1'b1;
                    end
                end
                PH_OBJ_FIRST: begin
                    if (text_byte == CH_RBRACE) begin
                        do_close = 1'b1;
                    end else if (text_byte == CH_QUOTE) begin
                        ph_next = PH_KSTR;
                    end else if (!is_space(text_byte)) begin
                        fail = 1'b1;
                    end
                end
                PH_KEY: begin
                    if (text_byte == CH_QUOTE) begin
                        ph_next = PH_KSTR;
                    end else if (!is_space(text_byte)) begin
                        fail = 1'b1;
                    end
                end
                PH_COLON: begin
                    if (text_byte == CH_COLON) begin
                        ph_next = PH_VALUE;
                    end else if (!is_space(text_byte)) begin
                        fail = 1'b1;
                    end
                end
                PH_AFTER: begin
                    if (is_space(text_byte)) begin
                        ph_next = PH_AFTER;
                    end else if (text_byte == CH_COMMA) begin
                        ph_next = top_is_obj ? PH_KEY : PH_VALUE;
                    end else if (text_byte == CH_RBRACE && top_is_obj) begin
                        do_close = 1'b1;
                    end else if (text_byte == CH_RBRACK && lvl_reg != '0 && !top_is_obj) begin
                        do_close = 1'b1;
                    end else begin
                        fail = 1'b1;
                    end
                end
                PH_DONE: begin
                    if (!is_space(text_byte)) begin
                        fail = 1'b1;
                    end
                end
                PH_STR, PH_KSTR: begin
                    if (text_byte == CH_QUOTE) begin
                        if (key) begin
                            ph_next = PH_COLON;
                        end else begin
                            ph_next = (lvl_reg == '0) ? PH_DONE : PH_AFTER;
                        end
                    end else if (text_byte < CH_SPACE) begin
                        fail = 1'b1;
                    end else if (text_byte == CH_BSLASH) begin
                        ph_next = key ? PH_KSTR_ESC : PH_STR_ESC;
                    end
                end
                PH_STR_ESC, PH_KSTR_ESC: begin
                    if (text_byte == CH_QUOTE || text_byte == CH_BSLASH ||
                        text_byte == CH_SLASH || text_byte == CH_LO_B ||
                        text_byte == CH_LO_F || text_byte == CH_LO_N ||
                        text_byte == CH_LO_R || text_byte == CH_LO_T) begin
                        ph_next = key ? PH_KSTR : PH_STR;
                    end else if (text_byte == CH_LO_U) begin
                        sub_next = 3'd0;
                        ph_next  = key ? PH_KSTR_HEX : PH_STR_HEX;
                    end else begin
                        fail = 1'b1;
                    end
                end
                PH_STR_HEX, PH_KSTR_HEX: begin
                    if (!is_hex(text_byte)) begin
                        fail = 1'b1;
                    end else if (sub_inc >= HEX_DIGITS) begin
                        sub_next = 3'd0;
                        ph_next  = key ? PH_KSTR : PH_STR;
                    end else begin
                        sub_next = sub_inc;
                    end
                end
                PH_LIT: begin
                    if (kind_reg > LIT_NULL || sub_reg >= lit_len(kind_reg) ||
                        lit_char(kind_reg, sub_reg) != text_byte) begin
                        fail = 1'b1;
                    end else if (sub_inc >= lit_len(kind_reg)) begin
                        sub_next = 3'd0;
                        ph_next  = (lvl_reg == '0) ? PH_DONE : PH_AFTER;
                    end else begin
                        sub_next = sub_inc;
                    end
                end
                default: begin
                    fail = 1'b1;
                end
            endcase
        end

        // start of a value
        if (do_start) begin
            if (too_deep) begin
                fail = 1'b1;
            end else if (text_byte == CH_QUOTE) begin
                ph_next = PH_STR;
            end else if (text_byte == CH_LO_T || text_byte == CH_LO_F ||
                         text_byte == CH_LO_N) begin
                kind_next = (text_byte == CH_LO_T) ? LIT_TRUE :
                            (text_byte == CH_LO_F) ? LIT_FALSE : LIT_NULL;
                sub_next  = 3'd1;
                ph_next   = PH_LIT;
            end else if (text_byte == CH_LBRACE || text_byte == CH_LBRACK) begin
                if (stack_full) begin
                    fail = 1'b1;
                end else begin
                    stk_ctrl.push     = 1'b1;
                    stk_ctrl.push_obj = (text_byte == CH_LBRACE);
                    lvl_next          = lvl_reg + LVL_W'(1);
                    ph_next = (text_byte == CH_LBRACE) ? PH_OBJ_FIRST : PH_ARR_FIRST;
                end
            end else if (text_byte == CH_MINUS || is_digit(text_byte)) begin
                ph_next = (text_byte == CH_MINUS) ? PH_NSIGN :
                          (text_byte == CH_ZERO) ? PH_NZERO : PH_NINT;
                if (eff_num == 6'd0) begin
                    fail      = 1'b1;
                    nlen_next = 6'd0;
                end else begin
                    nlen_next = 6'd1;
                end
            end else begin
                fail = 1'b1;
            end
        end

        // closing bracket or brace
        if (do_close) begin
            stk_ctrl.pop = 1'b1;
            lvl_next     = lvl_reg - LVL_W'(1);
            ph_next      = (lvl_reg == LVL_W'(1)) ? PH_DONE : PH_AFTER;
        end

        // end of text, by a zero byte or by the last byte of the request
        err_mid = err_reg | fail;
        if (end_now || (step && final_byte && !ended_reg)) begin
            ended_next = 1'b1;
            if (!err_mid && !(ph_next == PH_DONE ||
                              (lvl_next == '0 && num_can_end(ph_next)))) begin
                err_mid = 1'b1;
            end
        end
        err_next = err_mid;

        // result of this byte
        result.open_containers = 6'(lvl_next);
        if (final_byte) begin
            result.status = err_next ? ST_END_BAD : ST_END_VALID;
        end else begin
            result.status = err_next ? ST_ERROR : ST_FINE;
        end

        // last byte returns the parse to its start
        if (step && final_byte) begin
            ph_next    = PH_VALUE;
            lvl_next   = '0;
            sub_next   = 3'd0;
            kind_next  = 2'd0;
            nlen_next  = 6'd0;
            err_next   = 1'b0;
            ended_next = 1'b0;
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg    <= PH_VALUE;
            lvl_reg   <= '0;
            sub_reg   <= 3'd0;
            kind_reg  <= 2'd0;
            nlen_reg  <= 6'd0;
            err_reg   <= 1'b0;
            ended_reg <= 1'b0;
        end else if (step) begin
            ph_reg    <= ph_next;
            lvl_reg   <= lvl_next;
            sub_reg   <= sub_next;
            kind_reg  <= kind_next;
            nlen_reg  <= nlen_next;
            err_reg   <= err_next;
            ended_reg <= ended_next;
        end
    end

    assign level      = lvl_reg;
    assign level_next = step ? lvl_next : lvl_reg;

    // open count stays within the stack
    assert property (@(posedge aclk) disable iff (!aresetn)
        lvl_reg <= LVL_W'(MAX_LEVEL + 1))
        else $error("open count beyond stack depth");

    // the last byte leaves a clean parse for the next document
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && final_byte |=> lvl_reg == '0 && !err_reg && !ended_reg && ph_reg == PH_VALUE)
        else $error("parse not cleared after last byte");

    // an error holds until the document ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg && step && !final_byte |=> err_reg)
        else $error("error flag dropped inside a document");

    // nesting moves by at most one level per byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && !final_byte |=> lvl_reg == $past(lvl_reg) ||
            lvl_reg == $past(lvl_reg) + LVL_W'(1) || lvl_reg == $past(lvl_reg) - LVL_W'(1))
        else $error("nesting level jumped");

endmodule

>>> src/json_syntax_validator.sv
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+--------------------------------
// input     | in        | s_valid / s_ready      | s_text_byte, s_final_byte
// result    | out       | m_valid / m_ready      | m_status, m_open_containers
// config    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one byte per clock sustained while m_ready holds; a taken request passes the input register,
// then the parser logic into the result register, where its result is offered
// the rate rests on the combinational parser step and its one-deep nesting stack prefetch
// synchronous active-low reset; no memory clearing pass, so requests are taken right after reset
// the input register refills while a result waits, so a stall on m_ready costs no bubble
module json_syntax_validator import jsv_pkg::*; #(
    parameter int MAX_LEVEL     = JSV_MAX_LEVEL,
    parameter int NUMBER_BUFFER = JSV_NUMBER_BUFFER
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_final_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [5:0] m_open_containers,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [5:0] cfg_data
);

    localparam int LVL_W = $clog2(MAX_LEVEL + 2);

    logic             in_vld_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             out_vld_reg;
    result_t          res_reg;
    result_t          res_next;
    logic [5:0]       lvl_lim_reg;
    logic [5:0]       num_lim_reg;
    logic             fire;
    stack_ctrl_t      stk_ctrl;
    logic [LVL_W-1:0] level;
    logic [LVL_W-1:0] level_next;
    logic             top_obj;

    // the parser steps when a byte is held and the result slot is free
    assign fire    = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_text_byte;
            last_reg <= s_final_byte;
        end
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_lim_reg <= LEVEL_LIMIT_RESET;
            num_lim_reg <= NUMBER_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LEVEL_LIMIT:  lvl_lim_reg <= cfg_data;
                REG_NUMBER_LIMIT: num_lim_reg <= cfg_data;
                default:          lvl_lim_reg <= lvl_lim_reg;
            endcase
        end
    end

    jsv_core #(
        .MAX_LEVEL     (MAX_LEVEL),
        .NUMBER_BUFFER (NUMBER_BUFFER),
        .LVL_W         (LVL_W)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (fire),
        .text_byte    (byte_reg),
        .final_byte   (last_reg),
        .level_limit  (lvl_lim_reg),
        .number_limit (num_lim_reg),
        .top_obj      (top_obj),
        .stk_ctrl     (stk_ctrl),
        .level        (level),
        .level_next   (level_next),
        .result       (res_next)
    );

    jsv_stack #(
        .MAX_LEVEL (MAX_LEVEL),
        .LVL_W     (LVL_W)
    ) u_stack (
        .aclk       (aclk),
        .ctrl       (stk_ctrl),
        .level      (level),
        .level_next (level_next),
        .top_obj    (top_obj)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (fire) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_status          = res_reg.status;
    assign m_open_containers = res_reg.open_containers;

    // every parser step produces a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("parser step without result");

    // a held byte is not lost while the result side stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !fire |=> in_vld_reg && $stable(byte_reg) && $stable(last_reg))
        else $error("held byte dropped");

    // the verdict codes only come with the last byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !last_reg |=> m_status == ST_FINE || m_status == ST_ERROR)
        else $error("verdict on a byte that is not last");

endmodule

>>> bench/json_syntax_validator_tb.sv
module json_syntax_validator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsv_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 110;
    localparam int PHASE_COUNT  = 11;

    typedef struct {
        logic [7:0] text;
        logic       last;
    } text_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_text_byte = 8'h00;
    logic       s_final_byte = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_status;
    logic [5:0] m_open_containers;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = 1'b0;
    logic [5:0] cfg_data = 6'd0;

    json_syntax_validator uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_text_byte       (s_text_byte),
        .s_final_byte      (s_final_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_open_containers (m_open_containers),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // clock, 10 ns period
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    text_item_t text_queue [$];
    result_t    verdict_queue [$];
    logic [7:0] doc_bytes [$];
    int         queued_bytes = 0;
    int         mismatches = 0;
    int         cycle_count = 0;
    int         send_gap = 0;
    int         hold_off = 0;
    bit         steady = 1'b0;

    logic [7:0] noise_tokens [16] = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COMMA,
                                      CH_COLON, CH_QUOTE, CH_BSLASH, CH_MINUS, CH_PLUS,
                                      CH_DOT, CH_ZERO, CH_LO_E, CH_LO_T, CH_SPACE, CH_LO_U};

    // parser state mirrored on the bench side
    bit         nest_kind [JSV_MAX_LEVEL + 1];
    int         nest_depth;
    phase_t     parse_state;
    logic [2:0] sub_count;
    logic [1:0] lit_word;
    int         num_len;
    bit         doc_failed;
    bit         doc_ended;
    logic [5:0] depth_limit_reg;
    logic [5:0] num_limit_reg;

    // character classes
    function automatic bit ws_char(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic bit dec_char(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit hex_char(input logic [7:0] c);
        return dec_char(c) || (c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F);
    endfunction

    function automatic bit number_complete(input phase_t ph);
        return ph == PH_NZERO || ph == PH_NINT || ph == PH_NFRAC || ph == PH_NEXPD;
    endfunction

    // literal spelling
    function automatic logic [2:0] word_length(input logic [1:0] kind);
        return (kind == LIT_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [7:0] word_letter(input logic [1:0] kind, input logic [2:0] idx);
        logic [39:0] w;
        if (kind == LIT_FALSE) begin
            w = "false";
        end else if (kind == LIT_TRUE) begin
            w = {"true", 8'h00};
        end else begin
            w = {"null", 8'h00};
        end
        return w[39 - 8 * idx -: 8];
    endfunction

    // effective limits, clipped to the stack and the length counter
    function automatic int depth_cap();
        return (depth_limit_reg > JSV_MAX_LEVEL) ? JSV_MAX_LEVEL : int'(depth_limit_reg);
    endfunction

    function automatic int length_cap();
        return (num_limit_reg > JSV_NUMBER_BUFFER - 1) ? JSV_NUMBER_BUFFER - 1
                                                       : int'(num_limit_reg);
    endfunction

    function automatic bit inside_object();
        return (nest_depth == 0) ? 1'b0 : nest_kind[nest_depth - 1];
    endfunction

    task automatic clear_doc();
        foreach (nest_kind[i]) nest_kind[i] = 1'b0;
        nest_depth  = 0;
        parse_state = PH_VALUE;
        sub_count   = 3'd0;
        lit_word    = LIT_TRUE;
        num_len     = 0;
        doc_failed  = 1'b0;
        doc_ended   = 1'b0;
    endtask

    task automatic value_closed();
        parse_state = (nest_depth == 0) ? PH_DONE : PH_AFTER;
    endtask

    task automatic enter_container(input bit obj);
        if (nest_depth > JSV_MAX_LEVEL) begin
            doc_failed = 1'b1;
        end else begin
            nest_kind[nest_depth] = obj;
            nest_depth++;
            parse_state = obj ? PH_OBJ_FIRST : PH_ARR_FIRST;
        end
    endtask

    task automatic leave_container();
        if (nest_depth > 0) nest_depth--;
        value_closed();
    endtask

    task automatic count_number_char();
        if (num_len + 1 > length_cap()) doc_failed = 1'b1;
        else num_len++;
    endtask

    // first byte of a value
    task automatic open_value(input logic [7:0] c);
        if (nest_depth > depth_cap()) begin
            doc_failed = 1'b1;
        end else if (c == CH_QUOTE) begin
            parse_state = PH_STR;
        end else if (c == CH_LO_T || c == CH_LO_F || c == CH_LO_N) begin
            lit_word    = (c == CH_LO_T) ? LIT_TRUE : (c == CH_LO_F) ? LIT_FALSE : LIT_NULL;
            sub_count   = 3'd1;
            parse_state = PH_LIT;
        end else if (c == CH_LBRACE) begin
            enter_container(1'b1);
        end else if (c == CH_LBRACK) begin
            enter_container(1'b0);
        end else if (c == CH_MINUS || dec_char(c)) begin
            parse_state = (c == CH_MINUS) ? PH_NSIGN : (c == CH_ZERO) ? PH_NZERO : PH_NINT;
            num_len = 0;
            count_number_char();
        end else begin
            doc_failed = 1'b1;
        end
    endtask

    // number grammar; again is set when the byte ends the number and needs another look
    task automatic number_char(input logic [7:0] c, output bit again);
        bit     d;
        bit     e;
        bit     ok;
        phase_t nxt;
        d     = dec_char(c);
        e     = (c == CH_LO_E || c == CH_UP_E);
        ok    = 1'b1;
        nxt   = parse_state;
        again = 1'b0;
        case (parse_state)
            PH_NSIGN: begin
                if (c == CH_ZERO) nxt = PH_NZERO;
                else if (d) nxt = PH_NINT;
                else ok = 1'b0;
            end
            PH_NZERO: begin
                if (c == CH_DOT) nxt = PH_NDOT;
                else if (e) nxt = PH_NEXP;
                else ok = 1'b0;
            end
            PH_NINT: begin
                if (d) nxt = PH_NINT;
                else if (c == CH_DOT) nxt = PH_NDOT;
                else if (e) nxt = PH_NEXP;
                else ok = 1'b0;
            end
            PH_NDOT: begin
                if (d) nxt = PH_NFRAC;
                else ok = 1'b0;
            end
            PH_NFRAC: begin
                if (d) nxt = PH_NFRAC;
                else if (e) nxt = PH_NEXP;
                else ok = 1'b0;
            end
            PH_NEXP: begin
                if (c == CH_PLUS || c == CH_MINUS) nxt = PH_NEXPS;
                else if (d) nxt = PH_NEXPD;
                else ok = 1'b0;
            end
            PH_NEXPS: begin
                if (d) nxt = PH_NEXPD;
                else ok = 1'b0;
            end
            default: begin
                if (d) nxt = PH_NEXPD;
                else ok = 1'b0;
            end
        endcase
        if (ok) begin
            parse_state = nxt;
            count_number_char();
        end else if (number_complete(parse_state)) begin
            value_closed();
            again = 1'b1;
        end else begin
            doc_failed = 1'b1;
        end
    endtask

    // string body, escapes and the four hex digits of a unicode escape
    task automatic string_char(input logic [7:0] c, input bit key);
        phase_t plain;
        phase_t esc;
        phase_t hex;
        plain = key ? PH_KSTR : PH_STR;
        esc   = key ? PH_KSTR_ESC : PH_STR_ESC;
        hex   = key ? PH_KSTR_HEX : PH_STR_HEX;
        if (parse_state == plain) begin
            if (c == CH_QUOTE) begin
                if (key) parse_state = PH_COLON;
                else value_closed();
            end else if (c < CH_SPACE) begin
                doc_failed = 1'b1;
            end else if (c == CH_BSLASH) begin
                parse_state = esc;
            end
        end else if (parse_state == esc) begin
            if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_LO_B ||
                c == CH_LO_F || c == CH_LO_N || c == CH_LO_R || c == CH_LO_T) begin
                parse_state = plain;
            end else if (c == CH_LO_U) begin
                sub_count   = 3'd0;
                parse_state = hex;
            end else begin
                doc_failed = 1'b1;
            end
        end else if (!hex_char(c)) begin
            doc_failed = 1'b1;
        end else begin
            sub_count++;
            if (sub_count >= HEX_DIGITS) begin
                sub_count   = 3'd0;
                parse_state = plain;
            end
        end
    endtask

    // one non-zero byte through the parser
    task automatic consume_byte(input logic [7:0] c);
        bit again;
        again = 1'b1;
        if (parse_state >= PH_NSIGN && parse_state <= PH_NEXPD) number_char(c, again);
        if (again) begin
            case (parse_state)
                PH_VALUE: begin
                    if (!ws_char(c)) open_value(c);
                end
                PH_ARR_FIRST: begin
                    if (!ws_char(c)) begin
                        if (c == CH_RBRACK) leave_container();
                        else open_value(c);
                    end
                end
                PH_OBJ_FIRST: begin
                    if (!ws_char(c)) begin
                        if (c == CH_RBRACE) leave_container();
                        else if (c == CH_QUOTE) parse_state = PH_KSTR;
                        else doc_failed = 1'b1;
                    end
                end
                PH_KEY: begin
                    if (!ws_char(c)) begin
                        if (c == CH_QUOTE) parse_state = PH_KSTR;
                        else doc_failed = 1'b1;
                    end
                end
                PH_COLON: begin
                    if (!ws_char(c)) begin
                        if (c == CH_COLON) parse_state = PH_VALUE;
                        else doc_failed = 1'b1;
                    end
                end
                PH_AFTER: begin
                    if (!ws_char(c)) begin
                        if (c == CH_COMMA) parse_state = inside_object() ? PH_KEY : PH_VALUE;
                        else if (c == CH_RBRACE && inside_object()) leave_container();
                        else if (c == CH_RBRACK && nest_depth > 0 && !inside_object())
                            leave_container();
                        else doc_failed = 1'b1;
                    end
                end
                PH_DONE: begin
                    if (!ws_char(c)) doc_failed = 1'b1;
                end
                PH_STR, PH_STR_ESC, PH_STR_HEX: begin
                    string_char(c, 1'b0);
                end
                PH_KSTR, PH_KSTR_ESC, PH_KSTR_HEX: begin
                    string_char(c, 1'b1);
                end
                PH_LIT: begin
                    if (sub_count >= word_length(lit_word)) begin
                        doc_failed = 1'b1;
                    end else if (word_letter(lit_word, sub_count) != c) begin
                        doc_failed = 1'b1;
                    end else begin
                        sub_count++;
                        if (sub_count >= word_length(lit_word)) begin
                            sub_count = 3'd0;
                            value_closed();
                        end
                    end
                end
                default: begin
                    doc_failed = 1'b1;
                end
            endcase
        end
    endtask

    task automatic close_text();
        if (!doc_failed && !(parse_state == PH_DONE ||
                             (nest_depth == 0 && number_complete(parse_state))))
            doc_failed = 1'b1;
        doc_ended = 1'b1;
    endtask

    // expected report for one accepted byte
    task automatic validate_byte(input logic [7:0] c, input logic last);
        result_t r;
        if (!doc_failed && !doc_ended) begin
            if (c == CH_NUL) close_text();
            else consume_byte(c);
        end
        r.open_containers = 6'(nest_depth);
        if (last) begin
            if (!doc_ended) close_text();
            r.status = doc_failed ? ST_END_BAD : ST_END_VALID;
            clear_doc();
        end else begin
            r.status = doc_failed ? ST_ERROR : ST_FINE;
        end
        verdict_queue.push_back(r);
    endtask

    // document text builders
    task automatic put(input logic [7:0] c);
        doc_bytes.push_back(c);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endtask

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
        return noise_tokens[$urandom_range(0, 15)];
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic put_blank();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                case ($urandom_range(0, 3))
                    0:       put(CH_SPACE);
                    1:       put(CH_TAB);
                    2:       put(CH_LF);
                    default: put(CH_CR);
                endcase
            end
        end
    endtask

    task automatic put_string();
        int         pick;
        int         r;
        logic [7:0] c;
        logic [7:0] esc_set [8];
        esc_set = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LO_B, CH_LO_F, CH_LO_N, CH_LO_R, CH_LO_T};
        put(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                do begin
                    c = (pick < 4) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(32, 255));
                end while (c == CH_QUOTE || c == CH_BSLASH);
                put(c);
            end else if (pick < 8) begin
                put(CH_BSLASH);
                put(esc_set[$urandom_range(0, 7)]);
            end else begin
                // unicode escape, surrogates included
                put(CH_BSLASH);
                put(CH_LO_U);
                repeat (4) begin
                    r = $urandom_range(0, 21);
                    if (r < 10) put(CH_ZERO + 8'(r));
                    else if (r < 16) put(CH_LO_A + 8'(r - 10));
                    else put(CH_UP_A + 8'(r - 16));
                end
            end
        end
        put(CH_QUOTE);
    endtask

    task automatic put_key();
        put_string();
        put_blank();
        put(CH_COLON);
        put_blank();
    endtask

    task automatic put_scalar();
        int         pick;
        int         n;
        logic [1:0] kind;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            if ($urandom_range(0, 7) == 0) begin
                // plain integer at the length limit, from one digit under it to one digit over it
                n = length_cap() + int'($urandom_range(0, 2)) - 1;
                if (n < 1) n = 1;
                put(CH_ZERO + 8'($urandom_range(1, 9)));
                repeat (n - 1) put(rand_digit());
            end else begin
                if ($urandom_range(0, 2) == 0) put(CH_MINUS);
                if ($urandom_range(0, 3) == 0) begin
                    put(CH_ZERO);
                end else begin
                    put(CH_ZERO + 8'($urandom_range(1, 9)));
                    repeat ($urandom_range(0, 3)) put(rand_digit());
                end
                if ($urandom_range(0, 2) == 0) begin
                    put(CH_DOT);
                    repeat ($urandom_range(1, 3)) put(rand_digit());
                end
                if ($urandom_range(0, 3) == 0) begin
                    put(($urandom_range(0, 1) == 0) ? CH_LO_E : CH_UP_E);
                    case ($urandom_range(0, 2))
                        0:       put(CH_PLUS);
                        1:       put(CH_MINUS);
                        default: ;
                    endcase
                    repeat ($urandom_range(1, 2)) put(rand_digit());
                end
            end
        end else if (pick < 7) begin
            put_string();
        end else begin
            kind = 2'($urandom_range(0, 2));
            for (int i = 0; i < word_length(kind); i++) put(word_letter(kind, 3'(i)));
        end
    endtask

    // move the built document into the request queue, last byte flagged
    task automatic flush_document();
        text_item_t it;
        foreach (doc_bytes[i]) begin
            it.text = doc_bytes[i];
            it.last = (i == doc_bytes.size() - 1);
            text_queue.push_back(it);
        end
        queued_bytes += doc_bytes.size();
        doc_bytes.delete();
    endtask

    // one random document: mostly well formed, some deep, some damaged or pure noise
    task automatic queue_document();
        int mode;
        int top;
        int n;
        bit deep;
        bit obj;
        bit want_value;
        bit finished;
        bit kinds [$];
        int members [$];
        mode = $urandom_range(0, 19);
        deep = (mode < 2);
        doc_bytes.delete();
        if (mode == 6) begin
            repeat ($urandom_range(1, 6)) put(noise_byte());
        end else begin
            if (deep) begin
                top = depth_cap() + int'($urandom_range(0, 3)) - 1;
                if (top < 0) top = 0;
                if (top > JSV_MAX_LEVEL + 2) top = JSV_MAX_LEVEL + 2;
            end else begin
                top = $urandom_range(0, 4);
            end
            put_blank();
            want_value = 1'b1;
            finished   = 1'b0;
            while (!finished) begin
                if (want_value) begin
                    if (kinds.size() < top && (deep || $urandom_range(0, 2) == 0)) begin
                        obj = deep ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1));
                        put(obj ? CH_LBRACE : CH_LBRACK);
                        put_blank();
                        kinds.push_back(obj);
                        if (!deep && $urandom_range(0, 3) == 0) begin
                            members.push_back(0);
                            want_value = 1'b0;
                        end else begin
                            members.push_back(1);
                            if (obj) put_key();
                        end
                    end else begin
                        // empty container at the bottom of a deep chain
                        if (deep && $urandom_range(0, 2) == 0) begin
                            put(CH_LBRACK);
                            put(CH_RBRACK);
                        end else begin
                            put_scalar();
                        end
                        put_blank();
                        want_value = 1'b0;
                    end
                end else if (kinds.size() == 0) begin
                    finished = 1'b1;
                end else if (members[$] != 0 && members[$] < 3 && !deep &&
                             $urandom_range(0, 1) == 0) begin
                    put(CH_COMMA);
                    put_blank();
                    if (kinds[$]) put_key();
                    members[members.size() - 1]++;
                    want_value = 1'b1;
                end else begin
                    put(kinds[$] ? CH_RBRACE : CH_RBRACK);
                    put_blank();
                    void'(kinds.pop_back());
                    void'(members.pop_back());
                end
            end
        end
        case (mode)
            2, 3: doc_bytes[$urandom_range(0, doc_bytes.size() - 1)] = noise_byte();
            4: begin
                n = $urandom_range(1, doc_bytes.size());
                while (doc_bytes.size() > n) void'(doc_bytes.pop_back());
            end
            5: doc_bytes.insert($urandom_range(0, doc_bytes.size() - 1), CH_NUL);
            7: put(CH_NUL);
            default: ;
        endcase
        flush_document();
    endtask

    // configuration writes, only while the block is idle
    task automatic write_register(input logic idx, input logic [5:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_LEVEL_LIMIT) depth_limit_reg = val;
        else num_limit_reg = val;
    endtask

    task automatic program_limits(input logic [5:0] level, input logic [5:0] number);
        write_register(REG_LEVEL_LIMIT, level);
        write_register(REG_NUMBER_LIMIT, number);
    endtask

    task automatic drain();
        while (text_queue.size() != 0 || s_valid || verdict_queue.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // request driver
    always @(posedge aclk) begin
        logic       hold;
        text_item_t nxt;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            hold = s_valid;
            if (s_valid && s_ready) begin
                validate_byte(s_text_byte, s_final_byte);
                hold     = 1'b0;
                send_gap = steady ? 0 : $urandom_range(0, 5);
            end
            if (!hold) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (text_queue.size() != 0) begin
                    nxt = text_queue.pop_front();
                    s_text_byte  <= nxt.text;
                    s_final_byte <= nxt.last;
                    hold = 1'b1;
                end
            end
            s_valid <= hold;
        end
    end

    // result monitor and checker
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            hold_off = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_queue.size() == 0) begin
                    $error("unexpected result: m_status %0d, m_open_containers %0d",
                           m_status, m_open_containers);
                    mismatches++;
                end else begin
                    want = verdict_queue.pop_front();
                    if (m_status !== want.status) begin
                        $error("m_status: expected %0d, actual %0d", want.status, m_status);
                        mismatches++;
                    end
                    if (m_open_containers !== want.open_containers) begin
                        $error("m_open_containers: expected %0d, actual %0d",
                               want.open_containers, m_open_containers);
                        mismatches++;
                    end
                end
                hold_off = steady ? 0 : $urandom_range(0, 5);
            end
            if (hold_off > 0) begin
                hold_off--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        int level_plan [PHASE_COUNT];
        int number_plan [PHASE_COUNT];
        int start;
        level_plan  = '{32, 63, 0, 1, 33, 2, -1, -1, -1, 31, 32};
        number_plan = '{63, 63, 0, 1, 5, 63, -1, -1, -1, 2, 62};
        clear_doc();
        depth_limit_reg = LEVEL_LIMIT_RESET;
        num_limit_reg   = NUMBER_LIMIT_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset limits: object with surrogate escape and negative zero
        put_text("{\"\\uD8fF\":-0}");
        flush_document();
        // zero byte ends the text, the rest is ignored
        put_text("1");
        put(CH_NUL);
        put_text("x");
        flush_document();
        // sticky error
        put_text("]1");
        flush_document();
        put(8'hFF);
        flush_document();
        // zero byte alone cannot end a parse
        put(CH_NUL);
        flush_document();
        drain();

        // zero limits: empty container at the limit, too deep, number always rejected
        program_limits(6'd0, 6'd0);
        put_text("[]");
        flush_document();
        put_text("[0]");
        flush_document();
        put_text("5");
        flush_document();
        drain();

        // random documents under a range of limits
        for (int p = 0; p < PHASE_COUNT; p++) begin
            steady = (p == 1 || p == 6);
            program_limits((level_plan[p] < 0) ? 6'($urandom_range(0, 63)) : 6'(level_plan[p]),
                           (number_plan[p] < 0) ? 6'($urandom_range(0, 63))
                                                : 6'(number_plan[p]));
            start = queued_bytes;
            while (queued_bytes - start < PHASE_BYTES) queue_document();
            drain();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && verdict_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
